FILE: rtl/rhh_pkg.sv
package rhh_pkg;

    // Table geometry defaults and the smallest table that may be selected.
    localparam int DEF_MAX_SIZE_LOG2 = 10;
    localparam int DEF_OFFSET_BITS   = 32;
    localparam int MIN_SIZE_LOG2     = 3;

    // Field widths of the request and response items.
    localparam int HASH_BITS      = 32;
    localparam int PORT_OFF_BITS  = 32;
    localparam int PORT_IDX_BITS  = 10;
    localparam int PORT_DIST_BITS = 10;
    localparam int PORT_PRB_BITS  = 11;
    localparam int SIZE_REG_BITS  = 4;

    localparam logic [SIZE_REG_BITS-1:0] SIZE_LOG2_RESET = 4'd10;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_READ   = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;

    localparam t_status ST_PLACED  = 3'd0;
    localparam t_status ST_IGNORED = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_READ    = 3'd3;
    localparam t_status ST_CLEARED = 3'd4;

endpackage

FILE: rtl/rhh_if.sv
interface rhh_req_if
    import rhh_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_kind                    kind;
    logic [HASH_BITS-1:0]     entry_hash;
    logic [PORT_OFF_BITS-1:0] entry_offset;
    logic [PORT_IDX_BITS-1:0] slot_index;

    modport source (output valid, kind, entry_hash, entry_offset, slot_index, input ready);
    modport sink   (input valid, kind, entry_hash, entry_offset, slot_index, output ready);
endinterface

interface rhh_rsp_if
    import rhh_pkg::*;
();
    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic [HASH_BITS-1:0]      read_hash;
    logic [PORT_OFF_BITS-1:0]  read_offset;
    logic [PORT_DIST_BITS-1:0] read_distance;
    logic [PORT_PRB_BITS-1:0]  probe_count;

    modport source (output valid, status, read_hash, read_offset, read_distance, probe_count,
                    input ready);
    modport sink   (input valid, status, read_hash, read_offset, read_distance, probe_count,
                     output ready);
endinterface

FILE: rtl/rhh_table.sv
module rhh_table #(
    parameter int AW = 10,
    parameter int DW = 74
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1 << AW)-1];
    logic [DW-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/robin_hood_hash_insert.sv
// Robin Hood open-addressing hash table with linear probing. Each request item is an insert,
// a read of one slot, or a clear of the whole table, and each gives exactly one response
// item. An insert starts at slot (hash & (2^L - 1)), where L is the size register held in
// 3..MAX_SIZE_LOG2, and walks forward one slot per cycle through a table memory with one
// write port and a registered read port: the carried entry takes the first empty slot or
// swaps with a resident whose probe distance is shorter, and the displaced resident is
// carried on. A clear sweeps every one of the 2^MAX_SIZE_LOG2 slots, one per cycle, and then
// answers. After reset the same sweep runs once before the first item is taken. The block
// takes one item at a time; a finished response waits in an output register so the next
// item can be accepted while it is pending. A table that has no empty slot among the slots
// in use is reported full without any change. The size register may be written only while
// the block is idle.
module robin_hood_hash_insert
    import rhh_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = DEF_MAX_SIZE_LOG2,
    parameter int OFFSET_BITS   = DEF_OFFSET_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SIZE_REG_BITS-1:0] i_cfg_wdata,
    rhh_req_if.sink                  i_req,
    rhh_rsp_if.source                o_rsp
);

    localparam int AW = MAX_SIZE_LOG2;
    localparam int DW = HASH_BITS + OFFSET_BITS + AW;
    localparam int LW = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int NL = MAX_SIZE_LOG2 - MIN_SIZE_LOG2 + 1;
    localparam int IW = (NL > 1) ? $clog2(NL) : 1;
    localparam logic [AW-1:0] DIST_MAX = '1;

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PROBE = 6'b000100,
        S_READ  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                   r_state;
    logic [SIZE_REG_BITS-1:0] r_size_log2;
    logic [AW-1:0]            r_clr;

    // Occupied slots below 2^L, one counter for each selectable L.
    logic [AW:0]              r_fill [0:NL-1];

    // Carried entry and probe position.
    logic [HASH_BITS-1:0]     r_c_hash;
    logic [OFFSET_BITS-1:0]   r_c_off;
    logic [AW-1:0]            r_c_dist;
    logic [AW-1:0]            r_slot;
    logic [AW:0]              r_probes;

    // Response being built, and the output register.
    t_status                  r_res_status;
    logic [HASH_BITS-1:0]     r_res_hash;
    logic [PORT_OFF_BITS-1:0] r_res_off;
    logic [PORT_DIST_BITS-1:0] r_res_dist;
    logic [PORT_PRB_BITS-1:0] r_res_probes;

    logic                     r_ov;
    t_status                  r_o_status;
    logic [HASH_BITS-1:0]     r_o_hash;
    logic [PORT_OFF_BITS-1:0] r_o_off;
    logic [PORT_DIST_BITS-1:0] r_o_dist;
    logic [PORT_PRB_BITS-1:0] r_o_probes;

    logic [LW-1:0]            l_eff;
    logic [AW-1:0]            mask;
    logic [IW-1:0]            fill_idx;
    logic                     tbl_full;
    logic                     req_fire;
    logic                     rsp_load;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DW-1:0]            mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [DW-1:0]            mem_q;

    logic [HASH_BITS-1:0]     q_hash;
    logic [OFFSET_BITS-1:0]   q_off;
    logic [AW-1:0]            q_dist;
    logic                     take;
    logic [AW-1:0]            n_dist;
    logic [AW-1:0]            n_slot;
    logic [AW:0]              n_probes;

    // Effective table size, held in the supported range.
    always_comb begin
        if (int'(r_size_log2) < MIN_SIZE_LOG2) begin
            l_eff = LW'(MIN_SIZE_LOG2);
        end else if (int'(r_size_log2) > MAX_SIZE_LOG2) begin
            l_eff = LW'(MAX_SIZE_LOG2);
        end else begin
            l_eff = LW'(r_size_log2);
        end
    end

    assign mask     = ~({AW{1'b1}} << l_eff);
    assign fill_idx = IW'(l_eff - LW'(MIN_SIZE_LOG2));
    assign tbl_full = (r_fill[fill_idx] == ((AW + 1)'(1) << l_eff));
    assign req_fire = i_req.valid && i_req.ready;

    // A finished response moves into the output register once that register is free or
    // is being emptied in the same cycle.
    assign rsp_load = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    assign q_hash = mem_q[DW-1 -: HASH_BITS];
    assign q_off  = mem_q[AW +: OFFSET_BITS];
    assign q_dist = mem_q[AW-1:0];

    // The probe step: an empty slot or a shorter resident distance decides a swap, then the carried distance moves on.
    always_comb begin
        logic [AW-1:0] d;
        take     = (q_hash == '0) || (r_c_dist > q_dist);
        d        = take ? q_dist : r_c_dist;
        n_dist   = (d < DIST_MAX) ? d + AW'(1) : d;
        n_slot   = (r_slot + AW'(1)) & mask;
        n_probes = r_probes + (AW + 1)'(1);
    end

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {r_c_hash, r_c_off, r_c_dist};
        mem_raddr = n_slot;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_PROBE: begin
                mem_we = take;
            end
            S_IDLE: begin
                if (i_req.kind == KIND_READ) begin
                    mem_raddr = AW'(i_req.slot_index) & mask;
                end else begin
                    mem_raddr = AW'(i_req.entry_hash) & mask;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    rhh_table #(
        .AW (AW),
        .DW (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_size_log2 <= SIZE_LOG2_RESET;
            r_clr       <= '0;
            r_ov        <= 1'b0;
            for (int k = 0; k < NL; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_size_log2 <= i_cfg_wdata;
            end
            if (rsp_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (req_fire) begin
                        r_res_status <= ST_IGNORED;
                        r_res_hash   <= '0;
                        r_res_off    <= '0;
                        r_res_dist   <= '0;
                        r_res_probes <= '0;
                        r_c_hash     <= i_req.entry_hash;
                        r_c_off      <= OFFSET_BITS'(i_req.entry_offset);
                        r_c_dist     <= '0;
                        r_slot       <= mem_raddr;
                        r_probes     <= '0;
                        r_clr        <= '0;
                        r_state      <= S_DONE;
                        case (i_req.kind)
                            KIND_INSERT: begin
                                if (i_req.entry_hash != '0) begin
                                    if (tbl_full) begin
                                        r_res_status <= ST_FULL;
                                    end else begin
                                        r_state <= S_PROBE;
                                    end
                                end
                            end
                            KIND_READ: begin
                                r_state <= S_READ;
                            end
                            KIND_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_res_status <= ST_IGNORED;
                            end
                        endcase
                    end
                end

                S_PROBE: begin
                    r_probes <= n_probes;
                    if (take) begin
                        r_c_hash <= q_hash;
                        r_c_off  <= q_off;
                    end
                    if (q_hash == '0) begin
                        // The carried entry landed in an empty slot.
                        for (int k = 0; k < NL; k++) begin
                            if ((r_slot >> (k + MIN_SIZE_LOG2)) == '0) begin
                                r_fill[k] <= r_fill[k] + (AW + 1)'(1);
                            end
                        end
                        r_res_status <= ST_PLACED;
                        r_res_probes <= PORT_PRB_BITS'(n_probes);
                        r_state      <= S_DONE;
                    end else begin
                        r_c_dist <= n_dist;
                        r_slot   <= n_slot;
                    end
                end

                S_READ: begin
                    r_res_status <= ST_READ;
                    r_res_hash   <= q_hash;
                    r_res_off    <= PORT_OFF_BITS'(q_off);
                    r_res_dist   <= PORT_DIST_BITS'(q_dist);
                    r_state      <= S_DONE;
                end

                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        for (int k = 0; k < NL; k++) begin
                            r_fill[k] <= '0;
                        end
                        r_res_status <= ST_CLEARED;
                        r_state      <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (rsp_load) begin
                        r_o_status <= r_res_status;
                        r_o_hash   <= r_res_hash;
                        r_o_off    <= r_res_off;
                        r_o_dist   <= r_res_dist;
                        r_o_probes <= r_res_probes;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.read_hash      = r_o_hash;
    assign o_rsp.read_offset    = r_o_off;
    assign o_rsp.read_distance  = r_o_dist;
    assign o_rsp.probe_count    = r_o_probes;

    // A probe always carries a real entry.
    a_carry_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_c_hash != '0))
        else $error("probe running with an empty carried entry");

    // A table that is not full lets every insert land before the window is exhausted.
    a_probe_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_probes < ((AW + 1)'(1) << l_eff)))
        else $error("probe walked past every slot in use");

    // The smallest window can never hold more entries than the largest one.
    a_fill_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= r_fill[NL-1])
        else $error("occupancy counters out of order");

    // A placing insert visited at least one slot.
    a_placed_probes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_status == ST_PLACED)) |-> (r_o_probes != '0))
        else $error("placed insert reports no probes");

endmodule
